[hdl/lzss_pkg.sv]
// lzss_pkg: shared constants, types and state codes of the LZSS stream encoder.
// Used by the window cells, the group scanner, the top level and the testbench.
package lzss_pkg;

    localparam int WINDOW_BITS = 11;
    localparam int LENGTH_BITS = 4;
    localparam int RING_SIZE   = 1 << WINDOW_BITS;
    localparam int LOOK_SIZE   = (1 << LENGTH_BITS) + 1;
    localparam int HIST_SIZE   = RING_SIZE - LOOK_SIZE;
    localparam int LITERAL_MAX = 1;

    localparam int FILL_W      = $clog2(LOOK_SIZE + 1);
    localparam int LOOK_IDX_W  = $clog2(LOOK_SIZE);
    localparam int TOKEN_W     = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int TOKEN_CNT_W = $clog2(TOKEN_W + 1);

    localparam int GROUP_BITS  = 5;
    localparam int GROUP_SIZE  = 1 << GROUP_BITS;
    localparam int GROUP_COUNT = RING_SIZE / GROUP_SIZE;
    localparam int GROUP_IDX_W = WINDOW_BITS - GROUP_BITS;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic                    shift;
        logic                    init;
        logic                    step;
        logic                    commit;
        logic                    restart;
        logic [7:0]              cmp_byte;
        logic [FILL_W-1:0]       fill;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_STEP,
        ST_TOKEN,
        ST_EMIT,
        ST_FLUSH,
        ST_RESTART
    } lzss_state_t;

endpackage

[hdl/lzss_in_if.sv]
// lzss_in_if: valid/ready channel carrying one raw text word.
// Depends on nothing.
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

[hdl/lzss_out_if.sv]
// lzss_out_if: valid/ready channel carrying one packed code word.
// Depends on nothing.
interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       end_of_code;

    modport source (output valid, output code_byte, output end_of_code, input ready);
    modport sink   (input valid, input code_byte, input end_of_code, output ready);
endinterface

[hdl/lzss_cell.sv]
// lzss_cell: one window slot; holds a text byte and the match flags of the candidate
// currently checked at this slot. Depends on lzss_pkg.
module lzss_cell
    import lzss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [WINDOW_BITS-1:0] cell_index,
    input  cell_ctrl_t             ctrl,
    input  logic [7:0]             byte_in,
    input  logic                   match_in,
    output logic [7:0]             byte_out,
    output logic                   match_out,
    output logic                   cand_out
);

    logic [7:0] byte_reg;
    logic       cand_reg;
    logic       match_reg;
    logic [7:0] reset_byte;
    logic       in_range;
    logic       eq;
    logic [WINDOW_BITS:0] idx_ext;
    logic [WINDOW_BITS:0] lo_ext;
    logic [WINDOW_BITS:0] hi_ext;

    assign reset_byte = (cell_index < WINDOW_BITS'(HIST_SIZE)) ? SPACE_CHAR : 8'h00;
    assign idx_ext    = {1'b0, cell_index};
    assign lo_ext     = (WINDOW_BITS + 1)'(ctrl.fill);
    assign hi_ext     = lo_ext + (WINDOW_BITS + 1)'(HIST_SIZE - 1);
    assign in_range   = (idx_ext >= lo_ext) && (idx_ext <= hi_ext);
    assign eq         = (byte_reg == ctrl.cmp_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= reset_byte;
            cand_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.restart)
            begin
                byte_reg  <= reset_byte;
                match_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.shift)
                    byte_reg <= byte_in;
                if (ctrl.commit)
                    match_reg <= cand_reg;
            end
            if (ctrl.init)
                cand_reg <= in_range && eq;
            else if (ctrl.step)
                cand_reg <= match_in && eq;
        end
    end

    assign byte_out  = byte_reg;
    assign match_out = match_reg;
    assign cand_out  = cand_reg;

endmodule

[hdl/lzss_grp_scan.sv]
// lzss_grp_scan: registered first stage of the nearest-match search; per group of
// window slots, whether any flag is set and the lowest set slot. Depends on lzss_pkg.
module lzss_grp_scan
    import lzss_pkg::*;
(
    input  logic                   clk,
    input  logic [RING_SIZE-1:0]   flags,
    output logic [GROUP_COUNT-1:0] grp_any,
    output logic [GROUP_BITS-1:0]  grp_idx [GROUP_COUNT]
);

    logic [GROUP_COUNT-1:0] any_next;
    logic [GROUP_BITS-1:0]  idx_next [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] any_reg;
    logic [GROUP_BITS-1:0]  idx_reg [GROUP_COUNT];

    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            any_next[g] = 1'b0;
            idx_next[g] = '0;
            for (int i = GROUP_SIZE - 1; i >= 0; i--)
            begin
                if (flags[g * GROUP_SIZE + i])
                begin
                    any_next[g] = 1'b1;
                    idx_next[g] = GROUP_BITS'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg <= any_next;
        idx_reg <= idx_next;
    end

    assign grp_any = any_reg;
    assign grp_idx = idx_reg;

endmodule

[hdl/lzss_stream_encoder.sv]
// lzss_stream_encoder: top level of the LZSS encoder (11-bit window, 4-bit length).
// Depends on lzss_pkg, lzss_in_if, lzss_out_if, lzss_cell and lzss_grp_scan.
//
// Raw words are taken one per cycle while the 17-byte lookahead fills. The window is a
// chain of 2048 cells; text shifts up the chain and match flags shift down it, one
// compared byte per pass. Coding one token runs a cell compare, the registered group
// scan and a decision for each compared byte, for up to 17 bytes, then builds the
// token and shifts out one code bit (9 or 16 in all) per cycle, stalled while the code
// word register waits. After the last word the lookahead is drained, the padded final
// word is sent and the window is preset again with spaces.
module lzss_stream_encoder
    import lzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lzss_in_if.sink    raw,
    lzss_out_if.source coded
);

    lzss_state_t state_reg, state_next;

    logic [WINDOW_BITS-1:0] wp_reg, wp_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      jcnt_reg, jcnt_next;
    logic [FILL_W-1:0]      len_reg, len_next;
    logic [WINDOW_BITS-1:0] best_k_reg, best_k_next;
    logic [7:0]             lit_reg, lit_next;
    logic                   drain_reg, drain_next;
    logic [TOKEN_W-1:0]     tok_reg, tok_next;
    logic [TOKEN_CNT_W-1:0] tcnt_reg, tcnt_next;
    logic [7:0]             acc_reg, acc_next;
    logic [2:0]             pend_reg, pend_next;
    logic                   ovalid_reg, ovalid_next;
    logic [7:0]             obyte_reg, obyte_next;
    logic                   oend_reg, oend_next;

    cell_ctrl_t ctrl;

    logic [7:0]             byte_q  [RING_SIZE];
    logic                   match_q [RING_SIZE];
    logic [RING_SIZE-1:0]   cand_vec;
    logic [7:0]             look_q  [LOOK_SIZE];
    logic [LOOK_IDX_W-1:0]  lsel;

    logic [GROUP_COUNT-1:0] grp_any;
    logic [GROUP_BITS-1:0]  grp_idx [GROUP_COUNT];
    logic                   any_hit;
    logic [WINDOW_BITS-1:0] first_k;

    logic                   accept;
    logic                   out_free;
    logic                   is_lit;
    logic [WINDOW_BITS-1:0] match_pos;
    logic [FILL_W-1:0]      step_len;
    logic                   last_bit;

    // window chain
    for (genvar k = 0; k < RING_SIZE; k++)
    begin : g_cell
        logic [7:0] bin;
        logic       min;
        if (k == 0)
        begin : g_head
            assign bin = raw.data_byte;
        end
        else
        begin : g_body
            assign bin = byte_q[k-1];
        end
        if (k == RING_SIZE - 1)
        begin : g_tail
            assign min = 1'b0;
        end
        else
        begin : g_link
            assign min = match_q[k+1];
        end
        lzss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (WINDOW_BITS'(k)),
            .ctrl       (ctrl),
            .byte_in    (bin),
            .match_in   (min),
            .byte_out   (byte_q[k]),
            .match_out  (match_q[k]),
            .cand_out   (cand_vec[k])
        );
    end

    for (genvar k = 0; k < LOOK_SIZE; k++)
    begin : g_look
        assign look_q[k] = byte_q[k];
    end

    lzss_grp_scan u_scan (
        .clk     (clk),
        .flags   (cand_vec),
        .grp_any (grp_any),
        .grp_idx (grp_idx)
    );

    always_comb
    begin
        any_hit = 1'b0;
        first_k = '0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                any_hit = 1'b1;
                first_k = {GROUP_IDX_W'(g), grp_idx[g]};
            end
        end
    end

    assign accept    = raw.valid && raw.ready;
    assign raw.ready = (state_reg == ST_IDLE);
    assign out_free  = !ovalid_reg || coded.ready;
    assign lsel      = LOOK_IDX_W'(fill_reg - FILL_W'(1) - jcnt_reg);
    assign is_lit    = (len_reg <= FILL_W'(LITERAL_MAX));
    assign match_pos = WINDOW_BITS'(wp_reg - best_k_reg - WINDOW_BITS'(len_reg));
    assign step_len  = jcnt_reg + FILL_W'(1);
    assign last_bit  = (tcnt_reg == TOKEN_CNT_W'(1));

    assign coded.valid       = ovalid_reg;
    assign coded.code_byte   = obyte_reg;
    assign coded.end_of_code = oend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (raw.is_last || (fill_reg + FILL_W'(1) == FILL_W'(LOOK_SIZE))))
                    state_next = ST_INIT;
            end
            ST_INIT:   state_next = ST_SCAN;
            ST_STEP:   state_next = ST_SCAN;
            ST_SCAN:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (any_hit && (step_len < fill_reg))
                    state_next = ST_STEP;
                else
                    state_next = ST_TOKEN;
            end
            ST_TOKEN:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free && last_bit)
                begin
                    if (!drain_reg)
                        state_next = ST_IDLE;
                    else if (fill_reg != '0)
                        state_next = ST_INIT;
                    else if (pend_reg == 3'd7)
                        state_next = ST_RESTART;
                    else
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                    state_next = ST_RESTART;
            end
            ST_RESTART: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and cell controls
    always_comb
    begin
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        jcnt_next   = jcnt_reg;
        len_next    = len_reg;
        best_k_next = best_k_reg;
        lit_next    = lit_reg;
        drain_next  = drain_reg;
        tok_next    = tok_reg;
        tcnt_next   = tcnt_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !coded.ready;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;

        ctrl          = '0;
        ctrl.cmp_byte = look_q[lsel];
        ctrl.fill     = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.shift = 1'b1;
                    wp_next    = wp_reg + WINDOW_BITS'(1);
                    fill_next  = fill_reg + FILL_W'(1);
                    drain_next = raw.is_last;
                end
            end
            ST_INIT:
            begin
                ctrl.init = 1'b1;
                jcnt_next = '0;
                len_next  = '0;
                lit_next  = look_q[lsel];
            end
            ST_STEP:
            begin
                ctrl.step = 1'b1;
            end
            ST_DECIDE:
            begin
                if (any_hit)
                begin
                    ctrl.commit = 1'b1;
                    len_next    = step_len;
                    best_k_next = first_k;
                    if (step_len < fill_reg)
                        jcnt_next = step_len;
                end
            end
            ST_TOKEN:
            begin
                tok_next  = '0;
                jcnt_next = '0;
                if (is_lit)
                begin
                    tok_next[TOKEN_W-1]      = 1'b1;
                    tok_next[TOKEN_W-2 -: 8] = lit_reg;
                    tcnt_next                = TOKEN_CNT_W'(9);
                    fill_next                = fill_reg - FILL_W'(1);
                end
                else
                begin
                    tok_next  = {1'b0, match_pos, LENGTH_BITS'(len_reg - FILL_W'(2))};
                    tcnt_next = TOKEN_CNT_W'(TOKEN_W);
                    fill_next = fill_reg - len_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    acc_next[3'd7 - pend_reg] = tok_reg[TOKEN_W-1];
                    tok_next  = tok_reg << 1;
                    tcnt_next = tcnt_reg - TOKEN_CNT_W'(1);
                    pend_next = pend_reg + 3'd1;
                    if (pend_reg == 3'd7)
                    begin
                        ovalid_next = 1'b1;
                        obyte_next  = acc_next;
                        oend_next   = drain_reg && (fill_reg == '0) && last_bit;
                        acc_next    = '0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = acc_reg;
                    oend_next   = 1'b1;
                end
            end
            ST_RESTART:
            begin
                ctrl.restart = 1'b1;
                wp_next      = WINDOW_BITS'(HIST_SIZE);
                fill_next    = '0;
                acc_next     = '0;
                pend_next    = '0;
                drain_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= WINDOW_BITS'(HIST_SIZE);
            fill_reg   <= '0;
            jcnt_reg   <= '0;
            len_reg    <= '0;
            drain_reg  <= 1'b0;
            tcnt_reg   <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            jcnt_reg   <= jcnt_next;
            len_reg    <= len_next;
            drain_reg  <= drain_next;
            tcnt_reg   <= tcnt_next;
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_k_reg <= best_k_next;
        lit_reg    <= lit_next;
        tok_reg    <= tok_next;
        obyte_reg  <= obyte_next;
        oend_reg   <= oend_next;
    end

endmodule

[dv/lzss_tb_checker.sv]
// lzss_tb_checker: watches the raw and coded channels of the LZSS encoder, computes the
// expected code words and compares them. Depends on lzss_pkg, lzss_in_if, lzss_out_if.
`timescale 1ns / 100ps
module lzss_tb_checker
    import lzss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lzss_in_if.sink     raw,
    lzss_out_if.sink    coded,
    output int          fail_count,
    output int          pending_words
);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_code;
    } code_word_t;

    logic [7:0]         ring [RING_SIZE];
    logic [WINDOW_BITS-1:0] wr_pos;
    int unsigned        look_fill;
    logic [7:0]         bit_acc;
    int unsigned        bit_cnt;
    code_word_t         code_q[$];
    int unsigned        step_words;

    assign pending_words = code_q.size();

    function automatic void encoder_clear();
        for (int i = 0; i < RING_SIZE; i++)
            ring[i] = (i < HIST_SIZE) ? SPACE_CHAR : 8'h00;
        wr_pos    = WINDOW_BITS'(HIST_SIZE);
        look_fill = 0;
        bit_acc   = 8'h00;
        bit_cnt   = 0;
    endfunction

    function automatic void push_bit(logic b);
        bit_acc[7 - bit_cnt] = b;
        bit_cnt++;
        if (bit_cnt == 8)
        begin
            code_q.push_back('{bit_acc, 1'b0});
            step_words++;
            bit_acc = 8'h00;
            bit_cnt = 0;
        end
    endfunction

    function automatic void push_field(int unsigned value, int unsigned nbits);
        for (int k = nbits; k > 0; k--)
            push_bit(value[k-1]);
    endfunction

    function automatic void code_one_token();
        logic [WINDOW_BITS-1:0] start;
        logic [WINDOW_BITS-1:0] idx;
        logic [7:0]             head;
        int unsigned            best_len;
        int unsigned            best_pos;
        int unsigned            j;
        start    = wr_pos - WINDOW_BITS'(look_fill);
        head     = ring[start];
        best_len = 1;
        best_pos = 0;
        for (int d = 1; d <= HIST_SIZE; d++)
        begin
            idx = start - WINDOW_BITS'(d);
            if (ring[idx] == head)
            begin
                j = 1;
                while (j < look_fill &&
                       ring[WINDOW_BITS'(idx + j)] == ring[WINDOW_BITS'(start + j)])
                    j++;
                if (j > best_len)
                begin
                    best_len = j;
                    best_pos = idx;
                end
            end
        end
        if (best_len <= LITERAL_MAX)
        begin
            push_bit(1'b1);
            push_field(head, 8);
            look_fill -= 1;
        end
        else
        begin
            push_bit(1'b0);
            push_field(best_pos, WINDOW_BITS);
            push_field(best_len - 2, LENGTH_BITS);
            look_fill -= best_len;
        end
    endfunction

    function automatic void encode_word(logic [7:0] data, logic last);
        step_words = 0;
        ring[wr_pos] = data;
        wr_pos++;
        look_fill++;
        if (last)
        begin
            while (look_fill > 0)
                code_one_token();
            if (bit_cnt > 0)
                code_q.push_back('{bit_acc, 1'b1});
            else if (step_words > 0)
                code_q[code_q.size()-1].end_of_code = 1'b1;
            encoder_clear();
        end
        else if (look_fill >= LOOK_SIZE)
            code_one_token();
    endfunction

    initial
    begin
        fail_count = 0;
        encoder_clear();
    end

    always @(posedge clk)
    begin
        code_word_t exp_w;
        if (rst_n)
        begin
            if (coded.valid && coded.ready)
            begin
                if (code_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected code word %h end %b",
                                 coded.code_byte, coded.end_of_code);
                end
                else
                begin
                    exp_w = code_q.pop_front();
                    if (exp_w.code_byte !== coded.code_byte ||
                        exp_w.end_of_code !== coded.end_of_code)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("code word mismatch: exp %h/%b got %h/%b",
                                     exp_w.code_byte, exp_w.end_of_code,
                                     coded.code_byte, coded.end_of_code);
                    end
                end
            end
            if (raw.valid && raw.ready)
                encode_word(raw.data_byte, raw.is_last);
        end
    end

endmodule

[dv/lzss_stream_encoder_tb.sv]
// lzss_stream_encoder_tb: drives text streams into the LZSS encoder under varied idling.
// Depends on lzss_pkg, lzss_in_if, lzss_out_if, lzss_stream_encoder, lzss_tb_checker.
`timescale 1ns / 100ps
module lzss_stream_encoder_tb;
    import lzss_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   src_idle_pct;
    int   snk_stall_pct;
    logic hold_off;
    int   idle_cycles;
    logic [7:0] text_buf [$];

    lzss_in_if  raw ();
    lzss_out_if coded ();

    lzss_stream_encoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw.sink),
        .coded (coded.source)
    );

    lzss_tb_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .raw           (raw.sink),
        .coded         (coded.sink),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        coded.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            coded.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (raw.valid && raw.ready) || (coded.valid && coded.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            raw.valid <= 1'b0;
            @(posedge clk);
        end
        raw.valid     <= 1'b1;
        raw.data_byte <= data;
        raw.is_last   <= last;
        @(posedge clk);
        while (!raw.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input int len, input int mode);
        logic [7:0] b;
        text_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: b = 8'($urandom);
                1: b = 8'($urandom_range(3)) + 8'h61;
                2: b = (i >= 4 && $urandom_range(3) != 0) ?
                       text_buf[i - 1 - $urandom_range(i > 20 ? 20 : i - 1)] :
                       8'($urandom_range(7)) + 8'h41;
                default: b = ($urandom_range(2) == 0) ? 8'($urandom) : SPACE_CHAR;
            endcase
            text_buf.push_back(b);
            send_word(b, i == len - 1);
        end
        raw.valid <= 1'b0;
    endtask

    task automatic drain_out();
        while (pending_words > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        raw.valid     = 1'b0;
        raw.data_byte = 8'h00;
        raw.is_last   = 1'b0;
        hold_off      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single words including a space, extremes, overlapping repeat
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h20, 1'b1);
        for (int i = 0; i < 20; i++)
            send_word((i % 2) ? 8'hFF : 8'h00, i == 19);
        raw.valid <= 1'b0;
        drain_out();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 11 : 0;
            snk_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 11 : 0;
            if (ph == 0)
            begin
                hold_off <= 1'b1;
                fork
                    send_text(30, 2);
                    begin
                        repeat (400) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join
            end
            for (int t = 0; t < 4; t++)
                send_text($urandom_range(40, 1), $urandom_range(3));
            drain_out();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/lzss_pkg.sv
hdl/lzss_in_if.sv
hdl/lzss_out_if.sv
hdl/lzss_cell.sv
hdl/lzss_grp_scan.sv
hdl/lzss_stream_encoder.sv
dv/lzss_tb_checker.sv
dv/lzss_stream_encoder_tb.sv
